[rtl/core/bgpr_pkg.sv]
`default_nettype none

package bgpr_pkg;

  // Display geometry: 4 pages of 8 rows, 16 groups of 8 columns.
  localparam int unsigned PAGE_W      = 2;
  localparam int unsigned GROUP_W     = 4;
  localparam int unsigned RESULT_W    = PAGE_W + GROUP_W;
  localparam int unsigned COLS_PER_GRP = 8;
  localparam int unsigned ROWS_PER_PAGE = 8;
  localparam int unsigned PIXELS_W    = COLS_PER_GRP * ROWS_PER_PAGE;
  localparam int unsigned SLOT_W      = 6;

  // Bar heights run 0..31.
  localparam int unsigned HEIGHT_W    = 5;
  localparam int unsigned MAX_HEIGHT  = 31;

  // Slots touched by one column group at the narrowest bar width.
  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_W      = 2;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Slot counts of 16, 32 and 48/64 give bars of 8, 4 and 2 columns.
  typedef enum logic [1:0] {
    BW_8 = 2'd0,
    BW_4 = 2'd1,
    BW_2 = 2'd2
  } bar_width_e;

endpackage

`default_nettype wire

[rtl/core/bgpr_front.sv]
`default_nettype none

module bgpr_front #(
  parameter int unsigned MAX_SAMPLES  = 64,
  parameter int unsigned SAMPLE_WIDTH = 8,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned AW    = $clog2(MAX_SAMPLES),
  localparam int unsigned JOB_W = CNT_W + 2 * SAMPLE_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    take_i,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic                    last_i,
  output logic                         push_o,
  output logic [JOB_W-1:0]             job_o,
  input  wire logic [AW-1:0]           rd_addr_i,
  output logic [SAMPLE_WIDTH-1:0]      rd_data_o
);

  logic [SAMPLE_WIDTH-1:0] store_q [MAX_SAMPLES];
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [SAMPLE_WIDTH-1:0] min_q, min_d;
  logic [SAMPLE_WIDTH-1:0] max_q, max_d;
  logic [SAMPLE_WIDTH-1:0] rd_data_q;
  logic                    full;
  logic                    keep;

  assign full = (cnt_q == CNT_W'(MAX_SAMPLES));
  assign keep = take_i && !full;

  // Running statistics including the sample taken this cycle.
  always_comb begin
    cnt_d = cnt_q;
    min_d = min_q;
    max_d = max_q;
    if (keep) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (sample_i < min_q) begin
        min_d = sample_i;
      end
      if (sample_i > max_q) begin
        max_d = sample_i;
      end
    end
  end

  assign push_o = take_i && last_i;
  assign job_o  = {cnt_d, min_d, max_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      min_q <= '1;
      max_q <= '0;
    end else if (push_o) begin
      cnt_q <= '0;
      min_q <= '1;
      max_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      store_q[cnt_q[AW-1:0]] <= sample_i;
    end
    rd_data_q <= store_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/core/bgpr_queue.sv]
`default_nettype none

module bgpr_queue
  import bgpr_pkg::*;
#(
  parameter int unsigned DATA_W = 8,
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      data_o,
  output logic                   empty_o,
  output logic                   full_o
);

  logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [OCC_W-1:0]  occ_q;

  assign empty_o = (occ_q == '0);
  assign full_o  = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      occ_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        occ_q <= occ_q + OCC_W'(1);
      end else if (pop_i && !push_i) begin
        occ_q <= occ_q - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue popped while empty");

endmodule

`default_nettype wire

[rtl/core/bgpr_back.sv]
`default_nettype none

module bgpr_back
  import bgpr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES  = 64,
  parameter int unsigned SAMPLE_WIDTH = 8,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned AW    = $clog2(MAX_SAMPLES),
  localparam int unsigned JOB_W = CNT_W + 2 * SAMPLE_WIDTH,
  localparam int unsigned NUM_W = SAMPLE_WIDTH + HEIGHT_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    thin_i,
  input  wire logic                    job_valid_i,
  input  wire logic [JOB_W-1:0]        job_i,
  output logic                         pop_o,
  output logic [AW-1:0]                st_addr_o,
  input  wire logic [SAMPLE_WIDTH-1:0] st_data_i,
  output logic                         strobe_o,
  output logic [PIXELS_W-1:0]          pixels_o,
  output logic [PAGE_W-1:0]            page_o,
  output logic [GROUP_W-1:0]           group_o,
  output logic                         frame_end_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam int unsigned STEP_W = $clog2(HEIGHT_W);
  localparam logic [2:0]  PH_LAST = 3'(LANES + 1);

  logic [2:0]              state_q;
  logic [AW-1:0]           idx_q;
  logic [STEP_W-1:0]       step_q;
  logic [2:0]              ph_q;
  logic [RESULT_W-1:0]     res_q;
  logic                    strobe_q;

  logic [CNT_W-1:0]        n_q;
  logic [SAMPLE_WIDTH-1:0] min_q;
  logic [SAMPLE_WIDTH-1:0] den_q;
  logic                    flat_q;
  bar_width_e              mode_q;
  logic [NUM_W-1:0]        rem_q;
  logic [NUM_W-1:0]        dsh_q;
  logic [HEIGHT_W-1:0]     quo_q;

  logic [HEIGHT_W-1:0]     height_q [MAX_SAMPLES];
  logic [HEIGHT_W-1:0]     hrd_q;
  logic                    okp_q;
  logic [HEIGHT_W-1:0]     lane_h_q  [LANES];
  logic                    lane_ok_q [LANES];

  logic [PIXELS_W-1:0]     pixels_q;
  logic [PAGE_W-1:0]       page_q;
  logic [GROUP_W-1:0]      group_q;
  logic                    fend_q;

  logic [CNT_W-1:0]        job_n;
  logic [SAMPLE_WIDTH-1:0] job_min, job_max;
  logic [SAMPLE_WIDTH-1:0] diff;
  logic                    ge;
  logic                    last_idx;
  logic [SLOT_W-1:0]       base;
  logic [SLOT_W-1:0]       slot;
  logic                    slot_ok;
  logic [LANE_W-1:0]       cap_lane;
  logic [PAGE_W-1:0]       cur_page;
  logic [GROUP_W-1:0]      cur_group;
  logic [LANE_W-1:0]       col_lane [COLS_PER_GRP];
  logic                    col_lit  [COLS_PER_GRP];
  logic [HEIGHT_W:0]       row_sum  [COLS_PER_GRP][ROWS_PER_PAGE];
  logic [PIXELS_W-1:0]     pixels_d;

  assign {job_n, job_min, job_max} = job_i;
  assign diff      = st_data_i - min_q;
  assign ge        = (rem_q >= dsh_q);
  assign last_idx  = ((CNT_W'(idx_q) + CNT_W'(1)) == n_q);
  assign cur_page  = res_q[RESULT_W-1 -: PAGE_W];
  assign cur_group = res_q[GROUP_W-1:0];
  assign cap_lane  = LANE_W'(ph_q - 3'd1);

  // First slot of the column group; the group spans 1, 2 or 4 slots.
  always_comb begin
    case (mode_q)
      BW_8:    base = SLOT_W'(cur_group);
      BW_4:    base = SLOT_W'({cur_group, 1'b0});
      BW_2:    base = SLOT_W'({cur_group, 2'b00});
      default: base = '0;
    endcase
  end

  assign slot    = base + SLOT_W'(ph_q[LANE_W-1:0]);
  assign slot_ok = ((SLOT_W + 1)'(slot) < (SLOT_W + 1)'(n_q));

  assign st_addr_o = idx_q;
  assign pop_o     = (state_q == S_WRITE) && last_idx;

  // Column pattern within a bar, then the rows lit from the bottom up.
  always_comb begin
    for (int k = 0; k < COLS_PER_GRP; k++) begin
      case (mode_q)
        BW_8: begin
          col_lane[k] = '0;
          col_lit[k]  = thin_i ? (k == 4) : (k != 7);
        end
        BW_4: begin
          col_lane[k] = LANE_W'(k >> 2);
          col_lit[k]  = thin_i ? ((k % 4) == 2) : ((k % 4) != 3);
        end
        BW_2: begin
          col_lane[k] = LANE_W'(k >> 1);
          col_lit[k]  = thin_i ? ((k % 2) == 1) : ((k % 2) == 0);
        end
        default: begin
          col_lane[k] = '0;
          col_lit[k]  = 1'b0;
        end
      endcase
      for (int t = 0; t < ROWS_PER_PAGE; t++) begin
        row_sum[k][t] = (HEIGHT_W + 1)'({cur_page, 3'(t)})
                      + (HEIGHT_W + 1)'(lane_h_q[col_lane[k]]);
        pixels_d[k * ROWS_PER_PAGE + t] = col_lit[k] && lane_ok_q[col_lane[k]]
                      && (row_sum[k][t] >= (HEIGHT_W + 1)'(MAX_HEIGHT));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      step_q   <= '0;
      ph_q     <= '0;
      res_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            idx_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_PREP;
        end
        S_PREP: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(HEIGHT_W - 1)) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (last_idx) begin
            ph_q    <= '0;
            res_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_READ;
          end
        end
        S_EMIT: begin
          if (ph_q == PH_LAST) begin
            ph_q     <= '0;
            strobe_q <= 1'b1;
            res_q    <= res_q + RESULT_W'(1);
            if (res_q == '1) begin
              state_q <= S_IDLE;
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && job_valid_i) begin
      n_q    <= job_n;
      min_q  <= job_min;
      den_q  <= job_max - job_min;
      flat_q <= (job_max <= job_min);
      if (job_n <= CNT_W'(16)) begin
        mode_q <= BW_8;
      end else if (job_n <= CNT_W'(32)) begin
        mode_q <= BW_4;
      end else begin
        mode_q <= BW_2;
      end
    end
    if (state_q == S_PREP) begin
      rem_q <= {diff, 5'b0} - NUM_W'(diff);
      dsh_q <= {1'b0, den_q, 4'b0};
      quo_q <= '0;
    end
    if (state_q == S_DIV) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[HEIGHT_W-2:0], ge};
    end
    if (state_q == S_WRITE) begin
      height_q[idx_q] <= flat_q ? '0 : quo_q;
    end
    hrd_q <= height_q[slot[AW-1:0]];
    okp_q <= slot_ok;
    if ((state_q == S_EMIT) && (ph_q != '0) && (ph_q != PH_LAST)) begin
      lane_h_q[cap_lane]  <= hrd_q;
      lane_ok_q[cap_lane] <= okp_q;
    end
    if ((state_q == S_EMIT) && (ph_q == PH_LAST)) begin
      pixels_q <= pixels_d;
      page_q   <= cur_page;
      group_q  <= cur_group;
      fend_q   <= (res_q == '1);
    end
  end

  assign strobe_o    = strobe_q;
  assign pixels_o    = pixels_q;
  assign page_o      = page_q;
  assign group_o     = group_q;
  assign frame_end_o = fend_q;

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |=> !strobe_q)
    else $error("result strobe held for two cycles");

  a_frame_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && fend_q) |-> (page_q == '1 && group_q == '1))
    else $error("frame end flagged before the last column group");

endmodule

`default_nettype wire

[rtl/core/bar_graph_page_renderer_core.sv]
`default_nettype none

// Bar graph renderer for a 128 x 32 page-mode display.
//
// Input: raise start with sample_i and last_i; the transaction is taken on a
// rising edge where start is high and busy is low. Samples load one per cycle
// while busy is low. Up to MAX_SAMPLES are kept, later ones are dropped (a
// dropped sample that carries last_i still starts the frame).
// After the transaction with last_i, busy rises and the back end scales every
// stored sample to a 0..31 bar height with a 5-step shift-subtract divider
// (read, prepare, divide, write back for each sample). Busy stays high until
// the last sample is scaled, and also through the rest of the previous frame
// if that one is still streaming. Busy then drops and the next set may load
// while the frame streams out.
// Output: 64 results (page 0..3, column groups 0..15 in each page), each shown
// for one cycle with result_strobe_o; results come one after another, each
// after four reads of the bar height memory, one per lane. frame_end_o marks
// the 64th. The receiver cannot hold results off.
// Configuration: cfg_thin_mode_i is written whenever cfg_valid_i is high
// (cfg_ready_o is always high); write it only while the block is idle.
// Reset: clears thin mode, the sample count and min/max, the job queue and the back end's state.
// The sample and height memories are not cleared; only written entries are used.

module bar_graph_page_renderer_core
  import bgpr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES  = 64,
  parameter int unsigned SAMPLE_WIDTH = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic                    last_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic                    cfg_thin_mode_i,
  output logic                         result_strobe_o,
  output logic [PIXELS_W-1:0]          pixels_o,
  output logic [PAGE_W-1:0]            page_o,
  output logic [GROUP_W-1:0]           column_group_o,
  output logic                         frame_end_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW    = $clog2(MAX_SAMPLES);
  localparam int unsigned JOB_W = CNT_W + 2 * SAMPLE_WIDTH;

  logic                    thin_q;
  logic                    take;
  logic                    push;
  logic [JOB_W-1:0]        job_in;
  logic [JOB_W-1:0]        job_head;
  logic                    q_empty;
  logic                    q_full;
  logic                    pop;
  logic [AW-1:0]           st_addr;
  logic [SAMPLE_WIDTH-1:0] st_data;

  // Hold off new samples while a finished set waits to be scaled or is being scaled.
  assign busy        = !q_empty;
  assign take        = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thin_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thin_q <= cfg_thin_mode_i;
    end
  end

  // Front end: store samples, track min and max, post a job on the last one.
  bgpr_front #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .sample_i  (sample_i),
    .last_i    (last_i),
    .push_o    (push),
    .job_o     (job_in),
    .rd_addr_i (st_addr),
    .rd_data_o (st_data)
  );

  // Job queue between loading and rendering.
  bgpr_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back end: scale samples to heights, then stream the frame out.
  bgpr_back #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thin_i      (thin_q),
    .job_valid_i (!q_empty && !q_full || !q_empty),
    .job_i       (job_head),
    .pop_o       (pop),
    .st_addr_o   (st_addr),
    .st_data_i   (st_data),
    .strobe_o    (result_strobe_o),
    .pixels_o    (pixels_o),
    .page_o      (page_o),
    .group_o     (column_group_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire

[sim/tb_bar_graph_page_renderer_core.sv]
`timescale 1ns / 1ps

// Testbench for the page-mode bar graph renderer.
// The driver feeds sample transactions from a queue. The monitor predicts
// each rendered frame when its closing sample is accepted, and compares
// every strobed column word in order against that prediction.
module tb_bar_graph_page_renderer_core;
  import bgpr_pkg::*;

  localparam int unsigned STORE_DEPTH     = 64;
  localparam int unsigned GAP_MAX         = 18;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  // Idle margin after the last column word, before a register write or the end.
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned TAIL_CYCLES     = 1000;
  localparam int unsigned RANDOM_PHASES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  typedef struct {
    logic [7:0]  value;
    logic        last;
    int unsigned gap;
  } sample_txn_t;

  typedef struct {
    logic [PIXELS_W-1:0] pixels;
    logic [PAGE_W-1:0]   page;
    logic [GROUP_W-1:0]  group;
    logic                frame_end;
  } column_word_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [7:0]          sample_i        = '0;
  logic                last_i          = 1'b0;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_thin_mode_i = 1'b0;
  logic                result_strobe_o;
  logic [PIXELS_W-1:0] pixels_o;
  logic [PAGE_W-1:0]   page_o;
  logic [GROUP_W-1:0]  column_group_o;
  logic                frame_end_o;

  bar_graph_page_renderer_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sample_i        (sample_i),
    .last_i          (last_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_thin_mode_i (cfg_thin_mode_i),
    .result_strobe_o (result_strobe_o),
    .pixels_o        (pixels_o),
    .page_o          (page_o),
    .column_group_o  (column_group_o),
    .frame_end_o     (frame_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 0;
  end

  // Pending sample transactions and the column words still owed by the block.
  sample_txn_t  sample_fifo[$];
  column_word_t frame_words[$];

  // Shadow of the block state, at reset values.
  logic [7:0]  shadow_store [STORE_DEPTH];
  int unsigned shadow_count = 0;
  logic [7:0]  shadow_min   = 8'hFF;
  logic [7:0]  shadow_max   = 8'h00;
  logic        shadow_thin  = 1'b0;

  int unsigned n_issued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned cycle_count = 0;

  sample_txn_t next_txn;
  logic        have_next = 1'b0;

  // Height v = (s - min) * 31 / (max - min); a bar lights rows 31 down to 31 - v.
  // Flat data (max equal to min) gives height 0, the bottom row only.
  function automatic logic [31:0] bar_mask(logic [7:0] s);
    int unsigned h;
    h = 0;
    if (shadow_max > shadow_min)
      h = ((int'(s) - int'(shadow_min)) * 31) / (int'(shadow_max) - int'(shadow_min));
    if (h > 31) h = 31;
    return 32'hFFFF_FFFF << (31 - h);
  endfunction

  // Build the 64 column words of one frame from the held samples.
  function automatic void render_frame();
    logic [31:0]  masks [STORE_DEPTH];
    int unsigned  slots;
    int unsigned  width;
    int unsigned  col;
    int unsigned  slot;
    int unsigned  offs;
    logic [7:0]   col_byte;
    column_word_t w;
    slots = 16 * (1 + (shadow_count - 1) / 16);
    width = 128 / slots;
    // Blank the slots at or past the sample count.
    for (int i = 0; i < STORE_DEPTH; i++)
      masks[i] = (i < shadow_count) ? bar_mask(shadow_store[i]) : 32'h0;
    for (int r = 0; r < 64; r++) begin
      w.pixels    = '0;
      w.page      = PAGE_W'(r / 16);
      w.group     = GROUP_W'(r % 16);
      w.frame_end = (r == 63);
      for (int k = 0; k < 8; k++) begin
        col      = (r % 16) * 8 + k;
        slot     = (col / width) % STORE_DEPTH;
        offs     = col % width;
        col_byte = 8'(masks[slot] >> (8 * (r / 16)));
        // Thin bars keep only the centre column; full bars drop the last one.
        if (shadow_thin ? (offs != width / 2) : (offs == width - 1))
          col_byte = 8'h00;
        w.pixels[8*k +: 8] = col_byte;
      end
      frame_words.push_back(w);
    end
  endfunction

  // Store a sample; drop it once the store is full. A closing sample renders
  // the frame and returns count, min and max to their reset values.
  function automatic void load_sample(logic [7:0] s, logic is_last);
    if (shadow_count < STORE_DEPTH) begin
      shadow_store[shadow_count] = s;
      shadow_count++;
      if (s < shadow_min) shadow_min = s;
      if (s > shadow_max) shadow_max = s;
    end
    if (is_last) begin
      render_frame();
      shadow_count = 0;
      shadow_min   = 8'hFF;
      shadow_max   = 8'h00;
    end
  endfunction

  // Driver: change inputs on the falling edge. Hold start until the
  // transaction is taken, then wait out the gap drawn for the next one.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || n_accepted == n_issued) begin
      if (!have_next && sample_fifo.size() != 0) begin
        next_txn  = sample_fifo.pop_front();
        have_next = 1'b1;
      end
      if (!have_next) begin
        start <= 1'b0;
      end else if (next_txn.gap != 0) begin
        start <= 1'b0;
        next_txn.gap = next_txn.gap - 1;
      end else begin
        start     <= 1'b1;
        sample_i  <= next_txn.value;
        last_i    <= next_txn.last;
        have_next = 1'b0;
        n_issued++;
      end
    end
  end

  // Monitor: sample on the rising edge. Check the strobed word first, then
  // fold in an accepted sample, so the order within the step is fixed.
  always @(posedge clk_i) begin
    column_word_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_bar_graph_page_renderer_core: FAIL");
      $finish;
    end else if (rst_ni) begin
      if (result_strobe_o) begin
        if (frame_words.size() == 0) begin
          $display("%0t: column word with none expected: expected none, actual page %0d group %0d",
                   $time, page_o, column_group_o);
          n_errors++;
        end else begin
          want = frame_words.pop_front();
          if (pixels_o !== want.pixels) begin
            $display("%0t: pixels expected %h, actual %h", $time, want.pixels, pixels_o);
            n_errors++;
          end
          if (page_o !== want.page) begin
            $display("%0t: page expected %0d, actual %0d", $time, want.page, page_o);
            n_errors++;
          end
          if (column_group_o !== want.group) begin
            $display("%0t: column_group expected %0d, actual %0d",
                     $time, want.group, column_group_o);
            n_errors++;
          end
          if (frame_end_o !== want.frame_end) begin
            $display("%0t: frame_end expected %0b, actual %0b",
                     $time, want.frame_end, frame_end_o);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        load_sample(sample_i, last_i);
        n_accepted++;
      end
    end
  end

  task automatic push_sample(logic [7:0] value, logic is_last, logic burst);
    sample_txn_t t;
    t.value = value;
    t.last  = is_last;
    t.gap   = burst ? 0 : $urandom_range(0, GAP_MAX);
    sample_fifo.push_back(t);
  endtask

  // Wait until every transaction is taken and every column word has arrived,
  // then let a render in flight settle.
  task automatic wait_idle();
    while (sample_fifo.size() != 0 || have_next || n_accepted != n_issued ||
           frame_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_thin_mode(logic thin);
    @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_thin_mode_i <= thin;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_thin = thin;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One well-formed set: often small, some up to a full store, a few that
  // overflow it so the closing sample is dropped but still renders.
  task automatic push_random_set(output int unsigned count);
    int unsigned size_pick;
    int unsigned style;
    int unsigned base;
    logic        burst;
    logic [7:0]  v;
    size_pick = $urandom_range(0, 9);
    if (size_pick < 4)      count = $urandom_range(1, 16);
    else if (size_pick < 7) count = $urandom_range(17, 48);
    else if (size_pick < 9) count = $urandom_range(49, 64);
    else                    count = $urandom_range(65, 72);
    style = $urandom_range(0, 7);
    base  = $urandom_range(0, 250);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      case (style)
        0: begin
          v = 8'(base);
        end
        1: begin
          v = 8'(base + $urandom_range(0, 5));
        end
        default: begin
          v = 8'($urandom_range(0, 255));
        end
      endcase
      push_sample(v, i == count - 1, burst);
    end
  endtask

  initial begin
    logic [7:0]  ramp [17];
    int unsigned phase_items;
    int unsigned set_items;
    ramp = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40, 8'hC0, 8'h55,
             8'hAA, 8'h1F, 8'h20, 8'hC8, 8'h64, 8'h32, 8'h19, 8'hF0};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: both sample extremes over 32 slots, a lone sample, and a
    // flat set at full scale, all with full-width bars from reset.
    foreach (ramp[i]) push_sample(ramp[i], i == 16, 1'b0);
    push_sample(8'h80, 1'b1, 1'b0);
    repeat (3) push_sample(8'hFF, 1'b0, 1'b1);
    push_sample(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // Random sets, alternating the bar style between phases.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_thin_mode(p % 2 == 0);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        push_random_set(set_items);
        phase_items += set_items;
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0)
      $display("tb_bar_graph_page_renderer_core: PASS");
    else
      $display("tb_bar_graph_page_renderer_core: FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bgpr_pkg.sv
rtl/core/bgpr_front.sv
rtl/core/bgpr_queue.sv
rtl/core/bgpr_back.sv
rtl/core/bar_graph_page_renderer_core.sv
sim/tb_bar_graph_page_renderer_core.sv
